// File: hw/rtl/lfucd_pkg.sv
// shared types and constants for the lfu cache directory
`default_nettype none

package lfucd_pkg;

    localparam int unsigned CAP_W     = 5;
    localparam int unsigned REF_W     = 32;
    localparam int unsigned BYTES_W   = 24;
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned AGE_W     = 32;
    localparam int unsigned TOTAL_W   = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_PROBE  = 2'd0,
        OP_GET    = 2'd1,
        OP_INSERT = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 operation;
        logic [KEY_W-1:0]    key_tag;
        logic [REF_W-1:0]    payload_ref;
        logic [BYTES_W-1:0]  payload_bytes;
    } req_t;

    typedef struct packed {
        logic                found;
        logic [REF_W-1:0]    payload_out;
        logic                accepted;
        logic                evicted;
        logic [CAP_W-1:0]    entry_total;
        logic [TOTAL_W-1:0]  byte_total;
        logic [TOTAL_W-1:0]  hit_total;
        logic [TOTAL_W-1:0]  miss_total;
    } rsp_t;

    typedef struct packed {
        logic ready;
        logic start;
        logic scan;
        logic evict;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_clear;
        logic scan_last;
        logic need_evict;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/lfucd_stream_if.sv
// valid/ready channel carrying one word of a given type
`default_nettype none

interface lfucd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lfucd_ctrl.sv
// sequencing state machine for the lfu cache directory
`default_nettype none

module lfucd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire lfucd_pkg::sts_t sts,
    output lfucd_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_EVICT = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = sts.in_clear ? ST_WRITE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                cmd.evict  = sts.need_evict;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/lfucd_dp.sv
// entry store, scan evaluation, counters and result register
`default_nettype none

module lfucd_dp #(
    parameter int unsigned ENTRIES  = 16,
    parameter int unsigned TAG_BITS = 32,
    parameter int unsigned USE_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    lfucd_stream_if.sink                      req,
    lfucd_stream_if.source                    rsp,
    input  wire logic                         cfg_we,
    input  wire logic [lfucd_pkg::CAP_W-1:0]  cfg_wdata,
    input  wire lfucd_pkg::cmd_t              cmd,
    output lfucd_pkg::sts_t                   sts
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
    localparam int unsigned AGE_W = lfucd_pkg::AGE_W;
    localparam int unsigned TOT_W = lfucd_pkg::TOTAL_W;
    localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(ENTRIES);

    typedef struct packed {
        logic [TAG_BITS-1:0]             tag;
        logic [lfucd_pkg::REF_W-1:0]     payload;
        logic [lfucd_pkg::BYTES_W-1:0]   nbytes;
        logic [USE_BITS-1:0]             uses;
        logic [AGE_W-1:0]                age;
    } entry_t;

    entry_t mem [ENTRIES];
    entry_t rd_entry_reg;

    lfucd_pkg::req_t req_reg;
    lfucd_pkg::rsp_t rsp_reg;
    logic            rsp_valid_reg;

    logic [ENTRIES-1:0]              valid_reg;
    logic [CNT_W-1:0]                count_reg;
    logic [TOT_W-1:0]                bytes_reg;
    logic [TOT_W-1:0]                hits_reg;
    logic [TOT_W-1:0]                misses_reg;
    logic [AGE_W-1:0]                age_clock_reg;
    logic [lfucd_pkg::CAP_W-1:0]     cap_reg;

    logic [IDX_W:0]                  cnt_reg;
    logic [IDX_W-1:0]                eval_idx_reg;
    logic                            eval_vld_reg;

    logic                            hit_reg;
    logic [IDX_W-1:0]                hit_slot_reg;
    entry_t                          hit_entry_reg;
    logic                            free_found_reg;
    logic [IDX_W-1:0]                free_slot_reg;
    logic                            vic_found_reg;
    logic [IDX_W-1:0]                vic_slot_reg;
    logic [USE_BITS-1:0]             vic_uses_reg;
    logic [AGE_W-1:0]                vic_age_reg;
    logic [lfucd_pkg::BYTES_W-1:0]   vic_bytes_reg;
    logic                            evict_reg;

    logic [TAG_BITS-1:0]             req_tag;
    logic [CNT_W-1:0]                limit;
    logic                            scan_last;
    logic                            ev_valid;
    logic                            ev_match;
    logic                            vic_better;
    logic [AGE_W-1:0]                age_delta;

    logic                            mem_we;
    logic [IDX_W-1:0]                wr_slot;
    entry_t                          wr_entry;
    logic                            set_valid;
    logic                            clr_all;
    logic [CNT_W-1:0]                count_next;
    logic [TOT_W-1:0]                bytes_next;
    logic [TOT_W-1:0]                hits_next;
    logic [TOT_W-1:0]                misses_next;
    logic [AGE_W-1:0]                age_clock_next;
    lfucd_pkg::rsp_t                 rsp_next;

    assign req_tag   = TAG_BITS'(req_reg.key_tag);
    assign scan_last = (cnt_reg == SCAN_END);

    // effective capacity, clamped to 1..ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (32'(cap_reg) > ENTRIES)
        begin
            limit = CNT_W'(ENTRIES);
        end
        else
        begin
            limit = CNT_W'(cap_reg);
        end
    end

    assign req.ready      = cmd.ready;
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.data       = rsp_reg;

    assign sts.in_valid   = req.valid;
    assign sts.in_clear   = (req.data.operation == lfucd_pkg::OP_CLEAR);
    assign sts.scan_last  = scan_last;
    assign sts.need_evict = (req_reg.operation == lfucd_pkg::OP_INSERT) && !hit_reg
                            && (count_reg >= limit);
    assign sts.out_free   = !rsp_valid_reg || rsp.ready;

    // one entry evaluated per scan cycle
    always_comb
    begin
        ev_valid   = eval_vld_reg && valid_reg[eval_idx_reg];
        age_delta  = age_clock_reg - rd_entry_reg.age;
        ev_match   = ev_valid && (rd_entry_reg.tag == req_tag);
        vic_better = ev_valid && (!vic_found_reg || (rd_entry_reg.uses < vic_uses_reg)
                     || ((rd_entry_reg.uses == vic_uses_reg) && (age_delta > vic_age_reg)));
    end

    // commit of the operation
    always_comb
    begin
        logic [TOT_W:0] byte_sum;
        byte_sum       = {1'b0, bytes_reg} + (TOT_W + 1)'(req_reg.payload_bytes);
        mem_we         = 1'b0;
        wr_slot        = hit_slot_reg;
        wr_entry       = hit_entry_reg;
        set_valid      = 1'b0;
        clr_all        = 1'b0;
        count_next     = count_reg;
        bytes_next     = bytes_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        age_clock_next = age_clock_reg;
        rsp_next       = '0;
        case (req_reg.operation)
            lfucd_pkg::OP_PROBE:
            begin
                rsp_next.found = hit_reg;
                if (hit_reg)
                begin
                    if (hits_reg != '1)
                    begin
                        hits_next = hits_reg + TOT_W'(1);
                    end
                end
                else if (misses_reg != '1)
                begin
                    misses_next = misses_reg + TOT_W'(1);
                end
            end
            lfucd_pkg::OP_GET:
            begin
                if (hit_reg)
                begin
                    rsp_next.found       = 1'b1;
                    rsp_next.payload_out = hit_entry_reg.payload;
                    mem_we               = 1'b1;
                    if (hit_entry_reg.uses != '1)
                    begin
                        wr_entry.uses = hit_entry_reg.uses + USE_BITS'(1);
                    end
                    wr_entry.age   = age_clock_reg;
                    age_clock_next = age_clock_reg + AGE_W'(1);
                end
            end
            lfucd_pkg::OP_INSERT:
            begin
                if (!hit_reg)
                begin
                    rsp_next.accepted = 1'b1;
                    mem_we            = 1'b1;
                    set_valid         = 1'b1;
                    wr_slot           = evict_reg ? vic_slot_reg : free_slot_reg;
                    wr_entry.tag      = req_tag;
                    wr_entry.payload  = req_reg.payload_ref;
                    wr_entry.nbytes   = req_reg.payload_bytes;
                    wr_entry.uses     = USE_BITS'(1);
                    wr_entry.age      = age_clock_reg;
                    age_clock_next    = age_clock_reg + AGE_W'(1);
                    count_next        = count_reg + CNT_W'(1);
                    bytes_next        = byte_sum[TOT_W] ? '1 : byte_sum[TOT_W-1:0];
                end
            end
            lfucd_pkg::OP_CLEAR:
            begin
                clr_all        = 1'b1;
                count_next     = '0;
                bytes_next     = '0;
                hits_next      = '0;
                misses_next    = '0;
                age_clock_next = '0;
            end
            default:
            begin
                clr_all = 1'b0;
            end
        endcase
        rsp_next.evicted     = evict_reg;
        rsp_next.entry_total = lfucd_pkg::CAP_W'(count_next);
        rsp_next.byte_total  = bytes_next;
        rsp_next.hit_total   = hits_next;
        rsp_next.miss_total  = misses_next;
    end

    // entry store
    always_ff @(posedge clk)
    begin
        if (cmd.commit && mem_we)
        begin
            mem[wr_slot] <= wr_entry;
        end
        rd_entry_reg <= mem[cnt_reg[IDX_W-1:0]];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg <= req.data;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
        if (cmd.scan)
        begin
            eval_idx_reg <= cnt_reg[IDX_W-1:0];
            if (ev_match && !hit_reg)
            begin
                hit_slot_reg  <= eval_idx_reg;
                hit_entry_reg <= rd_entry_reg;
            end
            if (eval_vld_reg && !valid_reg[eval_idx_reg] && !free_found_reg)
            begin
                free_slot_reg <= eval_idx_reg;
            end
            if (vic_better)
            begin
                vic_slot_reg  <= eval_idx_reg;
                vic_uses_reg  <= rd_entry_reg.uses;
                vic_age_reg   <= age_delta;
                vic_bytes_reg <= rd_entry_reg.nbytes;
            end
        end
    end

    // control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            count_reg      <= '0;
            bytes_reg      <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            age_clock_reg  <= '0;
            cap_reg        <= lfucd_pkg::CAP_RESET;
            rsp_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            eval_vld_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
            evict_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.start)
            begin
                cnt_reg        <= '0;
                eval_vld_reg   <= 1'b0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                vic_found_reg  <= 1'b0;
                evict_reg      <= 1'b0;
            end
            if (cmd.scan)
            begin
                eval_vld_reg <= !scan_last;
                if (!scan_last)
                begin
                    cnt_reg <= cnt_reg + (IDX_W + 1)'(1);
                end
                if (ev_match)
                begin
                    hit_reg <= 1'b1;
                end
                if (eval_vld_reg && !valid_reg[eval_idx_reg])
                begin
                    free_found_reg <= 1'b1;
                end
                if (vic_better)
                begin
                    vic_found_reg <= 1'b1;
                end
            end
            // victim removal ahead of the insert write
            if (cmd.evict)
            begin
                evict_reg               <= 1'b1;
                valid_reg[vic_slot_reg] <= 1'b0;
                count_reg               <= count_reg - CNT_W'(1);
                bytes_reg               <= (bytes_reg >= TOT_W'(vic_bytes_reg))
                                           ? bytes_reg - TOT_W'(vic_bytes_reg) : '0;
            end
            if (cmd.commit)
            begin
                if (clr_all)
                begin
                    valid_reg <= '0;
                end
                else if (set_valid)
                begin
                    valid_reg[wr_slot] <= 1'b1;
                end
                count_reg     <= count_next;
                bytes_reg     <= bytes_next;
                hits_reg      <= hits_next;
                misses_reg    <= misses_next;
                age_clock_reg <= age_clock_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lfu_cache_directory.sv
// lfu cache directory: an input word is taken only while the directory is idle
// probe, get and insert scan every entry, one per cycle, through the entry store's read port
// clear skips the scan; the result sits in an output register until taken
// reset empties the directory, zeroes all counters and sets capacity to 16
`default_nettype none

module lfu_cache_directory #(
    parameter int unsigned ENTRIES  = 16,
    parameter int unsigned TAG_BITS = 32,
    parameter int unsigned USE_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    lfucd_stream_if.sink                      req,
    lfucd_stream_if.source                    rsp,
    input  wire logic                         cfg_we,
    input  wire logic [lfucd_pkg::CAP_W-1:0]  cfg_wdata
);

    lfucd_pkg::cmd_t cmd;
    lfucd_pkg::sts_t sts;

    lfucd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    lfucd_dp #(
        .ENTRIES  (ENTRIES),
        .TAG_BITS (TAG_BITS),
        .USE_BITS (USE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// File: bench/lfu_cache_directory_tb.sv
// testbench for the lfu cache directory: directed and random words checked against a predictor
module lfu_cache_directory_tb;

    localparam int unsigned SLOTS       = 16;
    localparam int unsigned USE_W       = 16;
    localparam int unsigned KEY_POOL    = 24;
    localparam int unsigned PHASE_WORDS = 165;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [lfucd_pkg::CAP_W-1:0]     cfg_wdata = '0;

    int unsigned         send_idle_pct  = 0;
    int unsigned         recv_stall_pct = 0;
    int unsigned         cycle_count    = 0;
    int unsigned         mismatch_count = 0;

    logic [lfucd_pkg::KEY_W-1:0]     key_pool [KEY_POOL];
    lfucd_pkg::rsp_t                 directory_replies_q [$];

    // predicted directory contents
    logic                            slot_valid [SLOTS];
    logic [lfucd_pkg::KEY_W-1:0]     slot_tag   [SLOTS];
    logic [lfucd_pkg::REF_W-1:0]     slot_ref   [SLOTS];
    logic [lfucd_pkg::BYTES_W-1:0]   slot_bytes [SLOTS];
    logic [USE_W-1:0]                slot_uses  [SLOTS];
    logic [lfucd_pkg::AGE_W-1:0]     slot_stamp [SLOTS];
    logic [lfucd_pkg::CAP_W-1:0]     live_count;
    logic [lfucd_pkg::TOTAL_W-1:0]   byte_sum;
    logic [lfucd_pkg::TOTAL_W-1:0]   hit_sum;
    logic [lfucd_pkg::TOTAL_W-1:0]   miss_sum;
    logic [lfucd_pkg::AGE_W-1:0]     stamp_clock;
    logic [lfucd_pkg::CAP_W-1:0]     capacity_reg;

    lfucd_stream_if #(.T(lfucd_pkg::req_t)) req_if ();
    lfucd_stream_if #(.T(lfucd_pkg::rsp_t)) rsp_if ();

    lfu_cache_directory u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void wipe_directory();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
        end
        live_count  = '0;
        byte_sum    = '0;
        hit_sum     = '0;
        miss_sum    = '0;
        stamp_clock = '0;
    endfunction

    function automatic lfucd_pkg::rsp_t predict_reply(input lfucd_pkg::req_t w);
        lfucd_pkg::rsp_t               r;
        int                            hit;
        int                            slot;
        int unsigned                   limit;
        logic [lfucd_pkg::AGE_W-1:0]   age;
        logic [lfucd_pkg::AGE_W-1:0]   oldest;
        r      = '0;
        hit    = -1;
        slot   = -1;
        oldest = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (hit < 0 && slot_valid[i] && slot_tag[i] == w.key_tag)
            begin
                hit = i;
            end
        end
        case (w.operation)
            lfucd_pkg::OP_PROBE:
            begin
                if (hit >= 0)
                begin
                    r.found = 1'b1;
                    if (hit_sum != '1)
                    begin
                        hit_sum = hit_sum + lfucd_pkg::TOTAL_W'(1);
                    end
                end
                else if (miss_sum != '1)
                begin
                    miss_sum = miss_sum + lfucd_pkg::TOTAL_W'(1);
                end
            end
            lfucd_pkg::OP_GET:
            begin
                if (hit >= 0)
                begin
                    r.found       = 1'b1;
                    r.payload_out = slot_ref[hit];
                    if (slot_uses[hit] != '1)
                    begin
                        slot_uses[hit] = slot_uses[hit] + USE_W'(1);
                    end
                    slot_stamp[hit] = stamp_clock;
                    stamp_clock     = stamp_clock + lfucd_pkg::AGE_W'(1);
                end
            end
            lfucd_pkg::OP_INSERT:
            begin
                if (hit < 0)
                begin
                    limit = (capacity_reg == 0) ? 1 :
                            (capacity_reg > SLOTS) ? SLOTS : capacity_reg;
                    if (live_count >= limit)
                    begin
                        // lowest use count loses, then the oldest stamp, then the lowest slot
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (slot_valid[i])
                            begin
                                age = stamp_clock - slot_stamp[i];
                                if (slot < 0 || slot_uses[i] < slot_uses[slot] ||
                                    (slot_uses[i] == slot_uses[slot] && age > oldest))
                                begin
                                    slot   = i;
                                    oldest = age;
                                end
                            end
                        end
                        if (slot >= 0)
                        begin
                            r.evicted = 1'b1;
                            if (byte_sum >= lfucd_pkg::TOTAL_W'(slot_bytes[slot]))
                            begin
                                byte_sum = byte_sum - lfucd_pkg::TOTAL_W'(slot_bytes[slot]);
                            end
                            else
                            begin
                                byte_sum = '0;
                            end
                            slot_valid[slot] = 1'b0;
                            live_count       = live_count - lfucd_pkg::CAP_W'(1);
                        end
                    end
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (slot < 0 && !slot_valid[i])
                        begin
                            slot = i;
                        end
                    end
                    if (slot >= 0)
                    begin
                        slot_valid[slot] = 1'b1;
                        slot_tag[slot]   = w.key_tag;
                        slot_ref[slot]   = w.payload_ref;
                        slot_bytes[slot] = w.payload_bytes;
                        slot_uses[slot]  = USE_W'(1);
                        slot_stamp[slot] = stamp_clock;
                        stamp_clock      = stamp_clock + lfucd_pkg::AGE_W'(1);
                        live_count       = live_count + lfucd_pkg::CAP_W'(1);
                        if (lfucd_pkg::TOTAL_W'(w.payload_bytes) > ('1 - byte_sum))
                        begin
                            byte_sum = '1;
                        end
                        else
                        begin
                            byte_sum = byte_sum + lfucd_pkg::TOTAL_W'(w.payload_bytes);
                        end
                        r.accepted = 1'b1;
                    end
                end
            end
            default:
            begin
                wipe_directory();
            end
        endcase
        r.entry_total = live_count;
        r.byte_total  = byte_sum;
        r.hit_total   = hit_sum;
        r.miss_total  = miss_sum;
        return r;
    endfunction

    function automatic lfucd_pkg::req_t make_word(input lfucd_pkg::op_t op,
                                                  input logic [lfucd_pkg::KEY_W-1:0] key,
                                                  input logic [lfucd_pkg::REF_W-1:0] pref,
                                                  input logic [lfucd_pkg::BYTES_W-1:0] nbytes);
        lfucd_pkg::req_t w;
        w.operation     = op;
        w.key_tag       = key;
        w.payload_ref   = pref;
        w.payload_bytes = nbytes;
        return w;
    endfunction

    function automatic lfucd_pkg::req_t random_word();
        lfucd_pkg::op_t                  op;
        int unsigned                     roll;
        int unsigned                     span;
        logic [lfucd_pkg::KEY_W-1:0]     key;
        logic [lfucd_pkg::BYTES_W-1:0]   nbytes;
        roll = $urandom_range(99);
        if (roll < 1)
        begin
            op = lfucd_pkg::OP_CLEAR;
        end
        else if (roll < 36)
        begin
            op = lfucd_pkg::OP_INSERT;
        end
        else if (roll < 68)
        begin
            op = lfucd_pkg::OP_GET;
        end
        else
        begin
            op = lfucd_pkg::OP_PROBE;
        end
        span = $urandom_range(1) ? 8 : KEY_POOL;
        if ($urandom_range(9) == 0)
        begin
            key = $urandom;
        end
        else
        begin
            key = key_pool[$urandom_range(span - 1)];
        end
        case ($urandom_range(9))
            0:       nbytes = '0;
            1:       nbytes = '1;
            default: nbytes = lfucd_pkg::BYTES_W'($urandom);
        endcase
        return make_word(op, key, $urandom, nbytes);
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : reply_check
        lfucd_pkg::rsp_t want;
        lfucd_pkg::rsp_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = rsp_if.data;
            if (directory_replies_q.size() == 0)
            begin
                $error("unexpected word: no request pending");
                mismatch_count++;
            end
            else
            begin
                want = directory_replies_q.pop_front();
                report_field("found", 32'(want.found), 32'(got.found));
                report_field("payload_out", want.payload_out, got.payload_out);
                report_field("accepted", 32'(want.accepted), 32'(got.accepted));
                report_field("evicted", 32'(want.evicted), 32'(got.evicted));
                report_field("entry_total", 32'(want.entry_total), 32'(got.entry_total));
                report_field("byte_total", want.byte_total, got.byte_total);
                report_field("hit_total", want.hit_total, got.hit_total);
                report_field("miss_total", want.miss_total, got.miss_total);
            end
        end
    end

    task automatic send_word(input lfucd_pkg::req_t w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.data  = w;
        do
        begin
            @(posedge clk);
        end
        while (!req_if.ready);
        directory_replies_q.push_back(predict_reply(w));
    endtask

    task automatic drain_replies();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (directory_replies_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [lfucd_pkg::CAP_W-1:0] value);
        drain_replies();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we       = 1'b0;
        capacity_reg = value;
    endtask

    task automatic test_basic_operations();
        send_word(make_word(lfucd_pkg::OP_PROBE, '0, '0, '0));
        send_word(make_word(lfucd_pkg::OP_GET, '1, '1, '1));
        send_word(make_word(lfucd_pkg::OP_INSERT, '0, '0, '0));
        send_word(make_word(lfucd_pkg::OP_INSERT, '1, '1, '1));
        send_word(make_word(lfucd_pkg::OP_INSERT, '0, 32'h1234_5678, 24'h00_0100));
        send_word(make_word(lfucd_pkg::OP_PROBE, '1, '0, '0));
        send_word(make_word(lfucd_pkg::OP_GET, '0, '0, '0));
        send_word(make_word(lfucd_pkg::OP_GET, '1, '0, '0));
        send_word(make_word(lfucd_pkg::OP_GET, 32'h5A5A_A5A5, '0, '0));
        send_word(make_word(lfucd_pkg::OP_CLEAR, '1, '1, '1));
        send_word(make_word(lfucd_pkg::OP_PROBE, '0, '0, '0));
    endtask

    task automatic test_lfu_eviction();
        write_capacity(lfucd_pkg::CAP_W'(2));
        send_word(make_word(lfucd_pkg::OP_INSERT, 32'hA, 32'h100A, 24'd10));
        send_word(make_word(lfucd_pkg::OP_INSERT, 32'hB, 32'h100B, 24'd20));
        // equal counts: the oldest goes
        send_word(make_word(lfucd_pkg::OP_INSERT, 32'hC, 32'h100C, 24'd30));
        send_word(make_word(lfucd_pkg::OP_PROBE, 32'hA, '0, '0));
        send_word(make_word(lfucd_pkg::OP_GET, 32'hB, '0, '0));
        // lowest count goes
        send_word(make_word(lfucd_pkg::OP_INSERT, 32'hD, 32'h100D, 24'd40));
        // capacity below the entry count
        write_capacity(lfucd_pkg::CAP_W'(0));
        send_word(make_word(lfucd_pkg::OP_INSERT, 32'hE, 32'h100E, 24'd50));
        send_word(make_word(lfucd_pkg::OP_INSERT, 32'hF, 32'h100F, 24'd60));
        write_capacity(lfucd_pkg::CAP_W'(31));
        send_word(make_word(lfucd_pkg::OP_INSERT, 32'h10, 32'h1010, 24'd70));
        send_word(make_word(lfucd_pkg::OP_CLEAR, '0, '0, '0));
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                       input logic [lfucd_pkg::CAP_W-1:0] cap,
                                       input int unsigned words);
        write_capacity(cap);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < words; n++)
        begin
            send_word(random_word());
            if ($urandom_range(63) == 0)
            begin
                drain_replies();
            end
        end
    endtask

    initial
    begin
        logic [lfucd_pkg::CAP_W-1:0] phase_cap [8];
        int unsigned                 idle_set  [4];
        int unsigned                 stall_set [4];
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        rsp_if.ready  = 1'b0;
        capacity_reg  = lfucd_pkg::CAP_RESET;
        wipe_directory();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++)
        begin
            key_pool[i] = $urandom;
        end
        phase_cap = '{lfucd_pkg::CAP_W'(16), lfucd_pkg::CAP_W'(31), lfucd_pkg::CAP_W'(1),
                      lfucd_pkg::CAP_W'(0), lfucd_pkg::CAP_W'(3), lfucd_pkg::CAP_W'(8),
                      lfucd_pkg::CAP_W'($urandom_range(15, 1)), lfucd_pkg::CAP_W'(16)};
        idle_set  = '{0, 88, 0, 37};
        stall_set = '{0, 0, 88, 37};
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_basic_operations();
        test_lfu_eviction();
        for (int p = 0; p < 8; p++)
        begin
            test_random_traffic(idle_set[p % 4], stall_set[p % 4], phase_cap[p], PHASE_WORDS);
        end

        drain_replies();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && directory_replies_q.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
